[hdl/sfl_pkg.sv]
// ---------------------------------------------------------------------------
// sfl_pkg
// shared constants, payload and control types and helper functions of the
// stereo freeze looper
// ---------------------------------------------------------------------------
`default_nettype none

package sfl_pkg;

  // store geometry
  localparam int unsigned STORE_DEPTH  = 65536;
  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);
  localparam int unsigned PAIR_W       = 2 * SAMPLE_WIDTH;

  // register field widths
  localparam int unsigned BLEN_W   = 17;
  localparam int unsigned LOOP_W   = 17;
  localparam int unsigned SPEED_W  = 18;
  localparam int unsigned OFFSET_W = 16;

  // play position, unsigned Q16.16 below the loop limit
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W     = LOOP_W + FRAC_BITS;
  localparam int unsigned POSX_W    = POS_W + 2;
  localparam int unsigned INT_W     = 16;

  // read index sum and its remainder pipeline
  localparam int unsigned SUM_W      = OFFSET_W + 1;
  localparam int unsigned MOD_STEPS  = 4;
  localparam int unsigned MOD_STAGES = (SUM_W + MOD_STEPS - 1) / MOD_STEPS;

  // queues
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_AW    = $clog2(CMD_DEPTH);
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);
  localparam int unsigned OCC_W     = $clog2(OUT_DEPTH + 1);

  // apb
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IW  = 3;

  typedef enum logic [REG_IW-1:0] {
    REG_BUFFER_LEN   = 3'd0,
    REG_LOOP_SIZE    = 3'd1,
    REG_PLAY_SPEED   = 3'd2,
    REG_START_OFFSET = 3'd3,
    REG_FREEZE_ON    = 3'd4,
    REG_LOOP_MODE    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;
  } in_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
  } out_pair_t;

  typedef struct packed {
    logic [BLEN_W-1:0]   buffer_len;
    logic [LOOP_W-1:0]   loop_size;
    logic [SPEED_W-1:0]  play_speed;
    logic [OFFSET_W-1:0] start_offset;
    logic                freeze_on;
    logic                loop_mode;
  } cfg_t;

  // one classified item on its way to the store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PAIR_W-1:0] wdata;
    logic [SUM_W-1:0]  rd_sum;
  } cmd_t;

  function automatic logic [BLEN_W-1:0] eff_buffer_len(input logic [BLEN_W-1:0] len);
    logic [BLEN_W-1:0] res;
    if (len == '0) begin
      res = BLEN_W'(1);
    end else if (32'(len) > 32'(STORE_DEPTH)) begin
      res = BLEN_W'(STORE_DEPTH);
    end else begin
      res = len;
    end
    return res;
  endfunction

  function automatic logic [LOOP_W-1:0] eff_loop_size(input logic [LOOP_W-1:0] len);
    logic [LOOP_W-1:0] res;
    if (len == '0) begin
      res = LOOP_W'(1);
    end else if (len > LOOP_W'(65536)) begin
      res = LOOP_W'(65536);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // a few restoring steps of the remainder, most significant shift first
  function automatic logic [SUM_W-1:0] mod_stage(input logic [SUM_W-1:0] r_in,
                                                 input logic [BLEN_W-1:0] divisor,
                                                 input int stage);
    logic [SUM_W-1:0] r;
    int k;
    r = r_in;
    for (int j = 0; j < int'(MOD_STEPS); j++) begin
      k = int'(SUM_W) - 1 - stage * int'(MOD_STEPS) - j;
      if (k >= 0) begin
        if (32'(r >> k) >= 32'(divisor)) begin
          r = r - SUM_W'(32'(divisor) << k);
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/sfl_ram.sv]
// ---------------------------------------------------------------------------
// sfl_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module sfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/sfl_regs.sv]
// ---------------------------------------------------------------------------
// sfl_regs
// apb configuration registers of the looper
// ---------------------------------------------------------------------------
`default_nettype none

module sfl_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfl_pkg::APB_AW-1:0]  paddr,
  input  logic [sfl_pkg::APB_DW-1:0]  pwdata,
  output logic [sfl_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output sfl_pkg::cfg_t               cfg_o,
  output logic                        speed_wr_o
);

  import sfl_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  logic [REG_IW-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d      = cfg_q;
    speed_wr_o = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_BUFFER_LEN:   cfg_d.buffer_len   = pwdata[BLEN_W-1:0];
        REG_LOOP_SIZE:    cfg_d.loop_size    = pwdata[LOOP_W-1:0];
        REG_PLAY_SPEED: begin
          cfg_d.play_speed = pwdata[SPEED_W-1:0];
          speed_wr_o       = 1'b1;
        end
        REG_START_OFFSET: cfg_d.start_offset = pwdata[OFFSET_W-1:0];
        REG_FREEZE_ON:    cfg_d.freeze_on    = pwdata[0];
        REG_LOOP_MODE:    cfg_d.loop_mode    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BUFFER_LEN:   prdata = APB_DW'(cfg_q.buffer_len);
      REG_LOOP_SIZE:    prdata = APB_DW'(cfg_q.loop_size);
      REG_PLAY_SPEED:   prdata = APB_DW'(cfg_q.play_speed);
      REG_START_OFFSET: prdata = APB_DW'(cfg_q.start_offset);
      REG_FREEZE_ON:    prdata = APB_DW'(cfg_q.freeze_on);
      REG_LOOP_MODE:    prdata = APB_DW'(cfg_q.loop_mode);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_len   <= BLEN_W'(65536);
      cfg_q.loop_size    <= LOOP_W'(65536);
      cfg_q.play_speed   <= SPEED_W'(65536);
      cfg_q.start_offset <= '0;
      cfg_q.freeze_on    <= 1'b0;
      cfg_q.loop_mode    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/sfl_front.sv]
// ---------------------------------------------------------------------------
// sfl_front
// accepts sample pairs, advances write index and play position, and emits
// one store transaction per item
// ---------------------------------------------------------------------------
`default_nettype none

module sfl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfl_pkg::cfg_t     cfg_i,
  input  logic              speed_wr_i,
  input  logic              push_i,
  input  sfl_pkg::in_pair_t pair_i,
  input  logic              room_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output sfl_pkg::cmd_t     cmd_o
);

  import sfl_pkg::*;

  logic [ADDR_W-1:0]  wr_idx_q, wr_idx_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               backward_q, backward_d;
  logic               accept;
  logic               flip;
  logic [BLEN_W-1:0]  blen;
  logic [LOOP_W-1:0]  loop_eff;
  logic [ADDR_W:0]    wr_idx_inc;
  logic [INT_W-1:0]   pos_int;
  logic signed [POSX_W-1:0] cur, spd, lim, p_raw, p_adj, p_fin;

  assign accept      = push_i && room_i;
  assign full_o      = !room_i;
  assign cmd_valid_o = accept;

  always_comb begin
    blen     = eff_buffer_len(cfg_i.buffer_len);
    loop_eff = eff_loop_size(cfg_i.loop_size);
    lim      = $signed({2'b00, loop_eff, {FRAC_BITS{1'b0}}});
    cur      = $signed({2'b00, pos_q});
    spd      = $signed({{(POSX_W-SPEED_W){1'b0}}, cfg_i.play_speed});
    p_raw    = backward_q ? cur - spd : cur + spd;
    flip     = 1'b0;
    if (!cfg_i.loop_mode) begin
      // wraparound
      if (p_raw >= lim) begin
        p_adj = p_raw - lim;
      end else if (p_raw < 0) begin
        p_adj = p_raw + lim;
      end else begin
        p_adj = p_raw;
      end
    end else begin
      // ping-pong reflection
      if (p_raw >= lim) begin
        p_adj = (lim <<< 1) - p_raw;
        flip  = 1'b1;
      end else if (p_raw < 0) begin
        p_adj = -p_raw;
        flip  = 1'b1;
      end else begin
        p_adj = p_raw;
      end
    end
    // still outside after one correction
    if (p_adj < 0) begin
      p_fin = '0;
    end else if (p_adj >= lim) begin
      p_fin = lim - 1;
    end else begin
      p_fin = p_adj;
    end
  end

  always_comb begin
    wr_idx_inc = {1'b0, wr_idx_q} + (ADDR_W+1)'(1);
    wr_idx_d   = wr_idx_q;
    pos_d      = pos_q;
    backward_d = backward_q;
    if (accept) begin
      wr_idx_d   = (32'(wr_idx_inc) >= 32'(blen)) ? '0 : wr_idx_inc[ADDR_W-1:0];
      pos_d      = p_fin[POS_W-1:0];
      backward_d = backward_q ^ flip;
    end
    if (speed_wr_i) begin
      backward_d = 1'b0;
    end
  end

  assign pos_int = p_fin[FRAC_BITS +: INT_W];

  always_comb begin
    cmd_o.wr_en   = !cfg_i.freeze_on;
    cmd_o.wr_addr = wr_idx_q;
    cmd_o.wdata   = PAIR_W'(pair_i);
    cmd_o.rd_sum  = SUM_W'(cfg_i.start_offset) + SUM_W'(pos_int);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      pos_q      <= '0;
      backward_q <= 1'b0;
    end else begin
      wr_idx_q   <= wr_idx_d;
      pos_q      <= pos_d;
      backward_q <= backward_d;
    end
  end

endmodule

`default_nettype wire

[hdl/sfl_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// sfl_cmd_fifo
// short transaction queue between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none

module sfl_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfl_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sfl_pkg::cmd_t data_o
);

  import sfl_pkg::*;

  cmd_t              slot_q [CMD_DEPTH];
  logic [CMD_AW-1:0] wptr_q, rptr_q;
  logic [CMD_AW:0]   count_q;

  assign full_o  = (count_q == (CMD_AW+1)'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wptr_q + CMD_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rptr_q + CMD_AW'(1);
      end
      count_q <= count_q + (CMD_AW+1)'(push_i) - (CMD_AW+1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

[hdl/sfl_back.sv]
// ---------------------------------------------------------------------------
// sfl_back
// read index remainder pipeline, sample store with write bypass, store
// clearing pass and result queue
// ---------------------------------------------------------------------------
`default_nettype none

module sfl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfl_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  sfl_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               clear_done_o,
  output logic               empty_o,
  input  logic               pop_i,
  output sfl_pkg::out_pair_t out_pair_o
);

  import sfl_pkg::*;

  logic               clr_done_q;
  logic [ADDR_W-1:0]  clr_addr_q;
  logic [OCC_W-1:0]   occ_q;
  logic               issue, out_pop;
  logic [BLEN_W-1:0]  blen;

  logic [MOD_STAGES:0] st_valid_q;
  cmd_t                st_q   [MOD_STAGES+1];
  cmd_t                st_adv [MOD_STAGES];
  cmd_t                fin;
  logic                fin_valid;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PAIR_W-1:0] ram_wdata, ram_rdata;
  logic              rd_valid_q, byp_q;
  logic [PAIR_W-1:0] byp_data_q, rd_pair;

  logic [PAIR_W-1:0] oq_q [OUT_DEPTH];
  logic [OUT_AW-1:0] owptr_q, orptr_q;
  logic [OCC_W-1:0]  ocount_q;

  assign blen         = eff_buffer_len(cfg_i.buffer_len);
  assign clear_done_o = clr_done_q;

  // credit: everything in flight plus everything queued fits the result queue
  assign issue     = cmd_valid_i && clr_done_q && (occ_q < OCC_W'(OUT_DEPTH));
  assign cmd_pop_o = issue;
  assign out_pop   = pop_i && !empty_o;

  always_comb begin
    for (int s = 0; s < int'(MOD_STAGES); s++) begin
      st_adv[s]        = st_q[s];
      st_adv[s].rd_sum = mod_stage(st_q[s].rd_sum, blen, s);
    end
  end

  assign fin       = st_q[MOD_STAGES];
  assign fin_valid = st_valid_q[MOD_STAGES];

  always_ff @(posedge clk_i) begin
    st_q[0] <= cmd_i;
    for (int s = 0; s < int'(MOD_STAGES); s++) begin
      st_q[s+1] <= st_adv[s];
    end
  end

  // store access: write and read of one item in the same cycle
  always_comb begin
    if (!clr_done_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = fin_valid && fin.wr_en;
      ram_waddr = fin.wr_addr;
      ram_wdata = fin.wdata;
    end
    ram_raddr = ADDR_W'(fin.rd_sum);
  end

  sfl_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    byp_data_q <= fin.wdata;
  end

  assign rd_pair = byp_q ? byp_data_q : ram_rdata;

  // result queue
  assign empty_o    = (ocount_q == '0);
  assign out_pair_o = out_pair_t'(oq_q[orptr_q]);

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      oq_q[owptr_q] <= rd_pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_done_q <= 1'b0;
      clr_addr_q <= '0;
      occ_q      <= '0;
      st_valid_q <= '0;
      rd_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      owptr_q    <= '0;
      orptr_q    <= '0;
      ocount_q   <= '0;
    end else begin
      if (!clr_done_q) begin
        if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_done_q <= 1'b1;
        end else begin
          clr_addr_q <= clr_addr_q + ADDR_W'(1);
        end
      end
      occ_q      <= occ_q + OCC_W'(issue) - OCC_W'(out_pop);
      st_valid_q <= {st_valid_q[MOD_STAGES-1:0], issue};
      rd_valid_q <= fin_valid;
      byp_q      <= fin_valid && fin.wr_en && (fin.wr_addr == ram_raddr);
      if (rd_valid_q) begin
        owptr_q <= (owptr_q == OUT_AW'(OUT_DEPTH - 1)) ? '0 : owptr_q + OUT_AW'(1);
      end
      if (out_pop) begin
        orptr_q <= (orptr_q == OUT_AW'(OUT_DEPTH - 1)) ? '0 : orptr_q + OUT_AW'(1);
      end
      ocount_q <= ocount_q + OCC_W'(rd_valid_q) - OCC_W'(out_pop);
    end
  end

endmodule

`default_nettype wire

[hdl/stereo_freeze_looper_top.sv]
// path: a pair accepted passes the command queue, the 5-stage read index remainder
//   pipeline, the registered store read and the result queue
// throughput: one pair per cycle when pop is held high, set by the single store port pair
// reset: after rst_ni rises the store is cleared one frame a cycle through all
//   STORE_DEPTH (65536) frames with full held high; registers are writable meanwhile
// ---------------------------------------------------------------------------
// stereo_freeze_looper_top
// freeze/loop buffer for stereo samples with variable speed playback
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_freeze_looper_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfl_pkg::APB_AW-1:0]  paddr,
  input  logic [sfl_pkg::APB_DW-1:0]  pwdata,
  output logic [sfl_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // sample input queue side
  input  logic                        push,
  output logic                        full,
  input  sfl_pkg::in_pair_t           in_pair_i,
  // result queue side
  output logic                        empty,
  input  logic                        pop,
  output sfl_pkg::out_pair_t          out_pair_o
);

  import sfl_pkg::*;

  cfg_t cfg;
  logic speed_wr;

  // front to queue
  logic cmd_push;
  cmd_t cmd_in;
  logic cmdq_full;

  // queue to back
  logic cmd_valid;
  cmd_t cmd_out;
  logic cmd_pop;

  logic clear_done;

  // register file, a play_speed write also resets the direction to forward
  sfl_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .speed_wr_o (speed_wr)
  );

  // front: owns write index, play position and direction; no item enters
  // until the clearing pass is done and while the queue is full
  sfl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .speed_wr_i  (speed_wr),
    .push_i      (push),
    .pair_i      (in_pair_i),
    .room_i      (clear_done && !cmdq_full),
    .full_o      (full),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  // decouples the position recurrence from the store side
  sfl_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  // back: modulo pipeline, store with same-cycle write bypass, result queue
  sfl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .clear_done_o (clear_done),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_pair_o   (out_pair_o)
  );

  // no sample transaction is taken while the store is still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> clear_done)
    else $error("sample accepted during store clearing");

  // no result can appear before the clearing pass has finished
  a_empty_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_done |-> empty)
    else $error("result visible during store clearing");

  // the front never overruns the command queue
  a_cmdq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmdq_full)
    else $error("command queue overflow");

  // the back only issues what the queue holds
  a_cmdq_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command queue underflow");

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for stereo_freeze_looper_top: a directed table, then
// random phases with varying register settings and idle patterns; every
// result is checked against the table or a cycle-free model of the looper
// ---------------------------------------------------------------------------

module tb;

  import sfl_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;       // extra wait for stray results after the drain
  localparam int PHASES       = 8;
  localparam int PHASE_PAIRS  = 119;

  // register numbers past the end of the map, writes must be dropped
  localparam logic [REG_IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {ROW_CFG, ROW_PAIR} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [REG_IW-1:0] reg_sel;
    logic [31:0]       value;
    in_pair_t          pair;
    bit                typed;   // want holds a hand-written result
    out_pair_t         want;
  } stim_row_t;

  // clock, reset and dut ports
  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [APB_AW-1:0]  paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               push    = 1'b0;
  logic               full;
  in_pair_t           in_pair = '0;
  logic               empty;
  logic               pop     = 1'b0;
  out_pair_t          out_pair;

  // model state: sample store, write pointer, Q16.16 position, direction
  logic [PAIR_W-1:0]  frame_mem [STORE_DEPTH];
  int unsigned        wr_ptr;
  longint             play_pos;
  bit                 going_back;

  // model copy of the register file
  int unsigned        buf_len_reg;
  int unsigned        loop_len_reg;
  int unsigned        speed_reg;
  int unsigned        offset_reg;
  bit                 freeze_reg;
  bit                 mode_reg;

  out_pair_t          expected_pairs[$];
  stim_row_t          directed_rows[$];
  int                 err_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  stereo_freeze_looper_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_pair_i  (in_pair),
    .empty      (empty),
    .pop        (pop),
    .out_pair_o (out_pair)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bits a register keeps out of a 32-bit write
  function automatic logic [31:0] reg_mask(input logic [REG_IW-1:0] sel);
    logic [31:0] m;
    case (sel)
      REG_BUFFER_LEN, REG_LOOP_SIZE: m = 32'h1FFFF;
      REG_PLAY_SPEED:                m = 32'h3FFFF;
      REG_START_OFFSET:              m = 32'hFFFF;
      REG_FREEZE_ON, REG_LOOP_MODE:  m = 32'h1;
      default:                       m = 32'h0;
    endcase
    return m;
  endfunction

  // mirror a register write into the model
  function automatic void mirror_reg_write(input logic [REG_IW-1:0] sel,
                                           input logic [31:0] value);
    logic [31:0] v;
    v = value & reg_mask(sel);
    case (sel)
      REG_BUFFER_LEN:   buf_len_reg  = v;
      REG_LOOP_SIZE:    loop_len_reg = v;
      REG_PLAY_SPEED: begin
        speed_reg  = v;
        going_back = 1'b0;   // a speed write restarts forward
      end
      REG_START_OFFSET: offset_reg   = v;
      REG_FREEZE_ON:    freeze_reg   = v[0];
      REG_LOOP_MODE:    mode_reg     = v[0];
      default: ;             // spare register numbers are dropped
    endcase
  endfunction

  // one sample pair through the looper: store, move the position, read back
  function automatic out_pair_t looper_next_pair(input in_pair_t d);
    int unsigned blen;
    int unsigned llen;
    longint      lim;
    longint      p;
    int unsigned ridx;
    // zero lengths act as one, oversize lengths are capped
    blen = (buf_len_reg == 0) ? 1 : (buf_len_reg > STORE_DEPTH) ? STORE_DEPTH : buf_len_reg;
    llen = (loop_len_reg == 0) ? 1 : (loop_len_reg > 65536) ? 65536 : loop_len_reg;
    lim  = longint'(llen) << FRAC_BITS;

    // write first, so the read may return this very pair
    if (!freeze_reg && wr_ptr < STORE_DEPTH) frame_mem[wr_ptr] = d;
    wr_ptr++;
    if (wr_ptr >= blen) wr_ptr = 0;

    p = going_back ? play_pos - longint'(speed_reg) : play_pos + longint'(speed_reg);
    if (!mode_reg) begin
      if (p >= lim) p -= lim;
      if (p < 0)    p += lim;
    end else begin
      if (p >= lim) begin
        p = lim - (p - lim);
        going_back = !going_back;
      end else if (p < 0) begin
        p = -p;
        going_back = !going_back;
      end
    end
    // one correction was not enough: clamp into the loop
    if (p < 0)    p = 0;
    if (p >= lim) p = lim - 1;
    play_pos = p;

    ridx = (offset_reg + 32'(p >> FRAC_BITS)) % blen;
    if (ridx >= STORE_DEPTH) ridx = 0;
    return out_pair_t'(frame_mem[ridx]);
  endfunction

  function automatic void add_cfg(input logic [REG_IW-1:0] sel, input logic [31:0] value);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.reg_sel = sel;
    r.value   = value;
    r.pair    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pair(input logic [23:0] l, input logic [23:0] rt,
                                   input bit typed, input logic [23:0] wl,
                                   input logic [23:0] wr);
    stim_row_t r;
    r.kind           = ROW_PAIR;
    r.reg_sel        = '0;
    r.value          = '0;
    r.pair.left_in   = l;
    r.pair.right_in  = rt;
    r.typed          = typed;
    r.want.left_out  = wl;
    r.want.right_out = wr;
    directed_rows.push_back(r);
  endfunction

  // apb write transaction, then read the register back where it exists
  task automatic apb_write(input logic [REG_IW-1:0] sel, input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mirror_reg_write(sel, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel <= REG_LOOP_MODE) begin
      @(negedge clk_i);
      psel    <= 1'b1;
      paddr   <= {sel, 2'b00};
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      rd = prdata;
      if (rd !== (value & reg_mask(sel))) begin
        $display("%0t: readback of register %0d, expected %0h, actual %0h",
                 $time, sel, value & reg_mask(sel), rd);
        err_count++;
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // offer one pair, hold it until accepted, then log what should come out
  task automatic send_pair(input in_pair_t d, input bit typed, input out_pair_t want);
    out_pair_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_pair <= d;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = looper_next_pair(d);
    expected_pairs.push_back(typed ? want : predicted);
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_results_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls on pop, changed on the falling edge
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  // result check on each accepted result transaction
  always @(posedge clk_i) begin
    out_pair_t exp_pair;
    if (rst_ni && pop && !empty) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result, actual %0d/%0d", $time,
                 out_pair.left_out, out_pair.right_out);
        err_count++;
      end else begin
        exp_pair = expected_pairs.pop_front();
        if (out_pair.left_out !== exp_pair.left_out ||
            out_pair.right_out !== exp_pair.right_out) begin
          $display("%0t: result mismatch, expected %0d/%0d, actual %0d/%0d", $time,
                   exp_pair.left_out, exp_pair.right_out,
                   out_pair.left_out, out_pair.right_out);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** stereo_freeze_looper_top: FAILED **");
      $finish;
    end
  end

  initial begin
    in_pair_t    rnd;
    logic [31:0] v_blen;
    logic [31:0] v_loop;
    logic [31:0] v_speed;
    logic [31:0] v_offset;
    logic [31:0] v_freeze;
    logic [31:0] v_mode;

    // model after reset
    for (int i = 0; i < STORE_DEPTH; i++) frame_mem[i] = '0;
    wr_ptr       = 0;
    play_pos     = 0;
    going_back   = 1'b0;
    buf_len_reg  = 65536;
    loop_len_reg = 65536;
    speed_reg    = 65536;
    offset_reg   = 0;
    freeze_reg   = 1'b0;
    mode_reg     = 1'b1;

    // directed table
    // reset defaults read one frame ahead of the writes: cleared store
    add_pair(24'h800000, 24'h7FFFFF, 1'b1, 24'h000000, 24'h000000);
    add_pair(24'h7FFFFF, 24'h800000, 1'b1, 24'h000000, 24'h000000);
    // offset of one frame back: each result is the pair just written
    add_cfg(REG_START_OFFSET, 32'hFFFF);
    add_pair(24'h000000, 24'h000000, 1'b1, 24'h000000, 24'h000000);
    add_pair(24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
    add_pair(24'h555555, 24'hAAAAAA, 1'b1, 24'h555555, 24'hAAAAAA);
    add_pair(24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 24'h7FFFFF);
    add_pair(24'h800000, 24'h800000, 1'b1, 24'h800000, 24'h800000);
    // freeze: pointer moves but the store keeps old frames
    add_cfg(REG_FREEZE_ON, 32'h1);
    add_pair(24'h123456, 24'h654321, 1'b0, '0, '0);
    add_pair(24'hABCDEF, 24'hFEDCBA, 1'b0, '0, '0);
    add_cfg(REG_FREEZE_ON, 32'h0);
    // zero buffer length, also shrinks below the write pointer
    add_cfg(REG_BUFFER_LEN, 32'h0);
    add_pair(24'h0F0F0F, 24'hF0F0F0, 1'b0, '0, '0);
    add_pair(24'h111111, 24'h222222, 1'b0, '0, '0);
    // oversize buffer length
    add_cfg(REG_BUFFER_LEN, 32'h1FFFF);
    add_pair(24'h333333, 24'h444444, 1'b0, '0, '0);
    // zero loop size at double speed in wrap mode: clamp at the top
    add_cfg(REG_BUFFER_LEN, 32'd8);
    add_cfg(REG_START_OFFSET, 32'h0);
    add_cfg(REG_LOOP_SIZE, 32'h0);
    add_cfg(REG_PLAY_SPEED, 32'd131072);
    add_cfg(REG_LOOP_MODE, 32'h0);
    add_pair(24'h010203, 24'h040506, 1'b0, '0, '0);
    add_pair(24'h070809, 24'h0A0B0C, 1'b0, '0, '0);
    // ping-pong: reflect, turn back, then clamp
    add_cfg(REG_LOOP_MODE, 32'h1);
    add_pair(24'h7F0000, 24'h00007F, 1'b0, '0, '0);
    add_pair(24'h800001, 24'hFFFFFE, 1'b0, '0, '0);
    add_pair(24'h3C3C3C, 24'hC3C3C3, 1'b0, '0, '0);
    // speed write turns playback forward again
    add_cfg(REG_LOOP_SIZE, 32'd3);
    add_cfg(REG_PLAY_SPEED, 32'd40000);
    add_pair(24'h246802, 24'h135791, 1'b0, '0, '0);
    add_pair(24'h999999, 24'h666666, 1'b0, '0, '0);
    // oversize loop size
    add_cfg(REG_LOOP_SIZE, 32'h1FFFF);
    add_pair(24'h5A5A5A, 24'hA5A5A5, 1'b0, '0, '0);
    // spare register numbers must not disturb anything
    add_cfg(REG_SPARE_LO, 32'hFFFFFFFF);
    add_cfg(REG_SPARE_HI, 32'hFFFFFFFF);
    add_pair(24'h0000FF, 24'hFF0000, 1'b0, '0, '0);

    // hold reset, then release it on a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the table; register writes only with nothing in flight
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_results_drained();
        apb_write(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each with its own register setting and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_drained();
      if (ph == 0) begin
        // lowest settings
        v_blen = 32'd1; v_loop = 32'd1; v_speed = 32'd0;
        v_offset = 32'd0; v_freeze = 32'd0; v_mode = 32'd0;
      end else if (ph == 1) begin
        // highest lengths and offset, double speed
        v_blen = 32'd65536; v_loop = 32'd65536; v_speed = 32'd131072;
        v_offset = 32'hFFFF; v_freeze = 32'd0; v_mode = 32'd1;
      end else begin
        // mostly short buffers so reads land on written frames
        case ($urandom_range(0, 7))
          0:       v_blen = 32'd0;
          1:       v_blen = 32'h1FFFF;
          2:       v_blen = 32'd65536;
          3:       v_blen = $urandom & 32'h1FFFF;
          default: v_blen = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 7))
          0:       v_loop = 32'd0;
          1:       v_loop = 32'h1FFFF;
          2:       v_loop = 32'd65536;
          3:       v_loop = $urandom & 32'h1FFFF;
          default: v_loop = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 7))
          0:       v_speed = 32'd0;
          1:       v_speed = 32'd131072;
          2:       v_speed = 32'h3FFFF;
          3:       v_speed = 32'd65536;
          4:       v_speed = $urandom & 32'h3FFFF;
          5:       v_speed = $urandom_range(0, 131072);
          default: v_speed = $urandom_range(0, 40000);
        endcase
        case ($urandom_range(0, 3))
          0:       v_offset = 32'hFFFF;
          1:       v_offset = $urandom & 32'hFFFF;
          default: v_offset = $urandom_range(0, 63);
        endcase
        v_freeze = ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0;
        v_mode   = $urandom_range(0, 1);
      end
      apb_write(REG_BUFFER_LEN, v_blen);
      apb_write(REG_LOOP_SIZE, v_loop);
      apb_write(REG_PLAY_SPEED, v_speed);
      apb_write(REG_START_OFFSET, v_offset);
      apb_write(REG_FREEZE_ON, v_freeze);
      apb_write(REG_LOOP_MODE, v_mode);
      if ($urandom_range(0, 3) == 0) begin
        apb_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      end

      // idle pattern: none, sender, receiver, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase

      for (int n = 0; n < PHASE_PAIRS; n++) begin
        rnd.left_in  = 24'($urandom);
        rnd.right_in = 24'($urandom);
        send_pair(rnd, 1'b0, '0);
      end
    end

    // drain, then give stray results time to show up
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("** stereo_freeze_looper_top: PASSED **");
    end else begin
      $display("** stereo_freeze_looper_top: FAILED **");
    end
    $finish;
  end

endmodule
